>>> src/lphm_pkg.sv
// Shared types and constants for the linear probing hash map.
`default_nettype none
package lphm_pkg;

	localparam int unsigned SLOTS_DEF = 1024;

	localparam logic [31:0] MIX_C1 = 32'h7feb352d;
	localparam logic [31:0] MIX_C2 = 32'h846ca68b;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_UPSERT = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		STAT_NEW     = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_ABSENT  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CHECK,
		ST_RESULT
	} st_t;

	typedef enum logic [2:0] {
		MIX_IDLE,
		MIX_MUL1,
		MIX_XS15,
		MIX_MUL2,
		MIX_XS16,
		MIX_DONE
	} mix_phase_t;

	typedef struct packed {
		logic        used;
		logic [31:0] key;
		logic [31:0] value;
	} entry_t;

endpackage
`default_nettype wire

>>> src/lphm_mix.sv
// Iterative 32-bit key mixer built around one shared multiplier.
`default_nettype none
module lphm_mix (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] key,
	output logic             done,
	output logic [31:0]      hash
);
	import lphm_pkg::*;

	mix_phase_t  phase_q;
	mix_phase_t  phase_d;
	logic [31:0] x_q;
	logic [31:0] mul_b;
	logic [31:0] prod;

	assign prod = x_q * mul_b;
	assign hash = x_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			MIX_IDLE: if (start) phase_d = MIX_MUL1;
			MIX_MUL1: phase_d = MIX_XS15;
			MIX_XS15: phase_d = MIX_MUL2;
			MIX_MUL2: phase_d = MIX_XS16;
			MIX_XS16: phase_d = MIX_DONE;
			MIX_DONE: phase_d = MIX_IDLE;
			default:  phase_d = MIX_IDLE;
		endcase
	end

	always_comb begin
		done  = (phase_q == MIX_DONE);
		mul_b = (phase_q == MIX_MUL1) ? MIX_C1 : MIX_C2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MIX_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			MIX_IDLE: if (start) x_q <= key ^ (key >> 16);
			MIX_MUL1: x_q <= prod;
			MIX_XS15: x_q <= x_q ^ (x_q >> 15);
			MIX_MUL2: x_q <= prod;
			MIX_XS16: x_q <= x_q ^ (x_q >> 16);
			default:  x_q <= x_q;
		endcase
	end

endmodule
`default_nettype wire

>>> src/linear_probe_hash_map.sv
// Top level: open addressing hash map with linear probing over one slot memory.
// Each request is hashed by the mixer, then probed slot by slot with a read and a compare per
// slot until an empty slot or a key match; a write refused because the table is full skips both
// and answers directly. The next request is taken only once the response is loaded, so a
// stalled response holds it off; the block takes one request at a time.
// After reset the slot memory is cleared slot by slot; no request is taken then.
`default_nettype none
module linear_probe_hash_map #(
	parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      found_value
);
	import lphm_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] HALF = IDX_W'(SLOTS / 2);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

	st_t             state_q;
	st_t             state_d;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       op_q;
	logic [31:0]      key_q;
	logic [31:0]      val_q;
	status_t          res_status_q;
	logic [31:0]      res_found_q;
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [31:0]      rsp_found_q;

	entry_t           mem [SLOTS];
	entry_t           rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	entry_t           mem_wdata;

	logic             mix_start;
	logic             mix_done;
	logic [31:0]      mix_hash;

	logic             full;
	logic             req_write;
	logic             accept;
	logic             refuse;
	logic             op_write;
	logic             probe_empty;
	logic             probe_hit;
	logic             rsp_load;

	lphm_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.key    (key),
		.done   (mix_done),
		.hash   (mix_hash)
	);

	assign full        = (count_q >= HALF);
	assign req_write   = (opcode == OP_INSERT) || (opcode == OP_UPSERT);
	assign op_write    = (op_q == OP_INSERT) || (op_q == OP_UPSERT);
	assign accept      = req_valid && !req_stall;
	assign refuse      = req_write && full;
	assign probe_empty = !rd_q.used;
	assign probe_hit   = rd_q.used && (rd_q.key == key_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) state_d = refuse ? ST_RESULT : ST_HASH;
			end
			ST_HASH:   if (mix_done) state_d = ST_READ;
			ST_READ:   state_d = ST_CHECK;
			ST_CHECK:  state_d = (probe_empty || probe_hit) ? ST_RESULT : ST_READ;
			ST_RESULT: if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		mix_start = (state_q == ST_IDLE) && req_valid && !refuse;
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = '{used: 1'b1, key: key_q, value: val_q};
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '{used: 1'b0, key: 32'd0, value: 32'd0};
			end
			ST_CHECK:  mem_we = op_write && probe_empty;
			ST_RESULT: rsp_load = !rsp_valid_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (state_q == ST_CHECK && mem_we) count_q <= count_q + IDX_W'(1);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= opcode;
			key_q        <= key;
			val_q        <= value;
			res_status_q <= STAT_FULL;
			res_found_q  <= '0;
		end
		if (state_q == ST_HASH && mix_done) idx_q <= mix_hash[IDX_W-1:0];
		if (state_q == ST_CHECK) begin
			if (probe_hit) begin
				res_status_q <= STAT_PRESENT;
				res_found_q  <= (op_q == OP_INSERT) ? 32'd0 : rd_q.value;
			end else if (probe_empty) begin
				res_status_q <= op_write ? STAT_NEW : STAT_ABSENT;
				res_found_q  <= (op_q == OP_UPSERT) ? val_q : 32'd0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_found_q  <= res_found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		rd_q <= mem[idx_q];
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign found_value = rsp_found_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= HALF)
		else $error("entry count above half the slots");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> req_stall)
		else $error("request taken during clear");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && mem_we) |=> (count_q == $past(count_q) + IDX_W'(1)))
		else $error("count not advanced on store");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && res_status_q == STAT_FULL) |-> full)
		else $error("full status below half load");
`endif

endmodule
`default_nettype wire

>>> sim/map_response_checker.sv
// Checker for the hash map: predicts each response beat and compares it with the block.
`timescale 1ns / 100ps
module map_response_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	input  wire logic               rsp_valid,
	input  wire logic               rsp_stall,
	input  wire logic [1:0]         status,
	input  wire logic signed [31:0] found_value,
	output int                      fail_count,
	output int                      pending
);
	import lphm_pkg::*;

	typedef struct packed {
		status_t            st;
		logic signed [31:0] val;
	} map_answer_t;

	logic signed [31:0] stored_val [int];
	int unsigned        stored_count;
	map_answer_t        answer_q [$];
	map_answer_t        want;

	function automatic map_answer_t map_apply(logic [1:0] op, logic signed [31:0] k,
			logic signed [31:0] v);
		map_answer_t a;
		a.val = '0;
		if (op == OP_INSERT || op == OP_UPSERT) begin
			if (stored_count * 2 >= SLOTS_DEF) begin
				a.st = STAT_FULL;
			end else if (stored_val.exists(k)) begin
				a.st = STAT_PRESENT;
				if (op == OP_UPSERT)
					a.val = stored_val[k];
			end else begin
				stored_val[k] = v;
				stored_count++;
				a.st = STAT_NEW;
				if (op == OP_UPSERT)
					a.val = v;
			end
		end else if (stored_val.exists(k)) begin
			a.st = STAT_PRESENT;
			a.val = stored_val[k];
		end else begin
			a.st = STAT_ABSENT;
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_val.delete();
			stored_count = 0;
			answer_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					$display("%0t: response beat with none expected: status %0d value %0d",
						$time, status, found_value);
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (status !== want.st) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.st, status);
						fail_count++;
					end
					if (found_value !== want.val) begin
						$display("%0t: found_value mismatch: expected %0d, got %0d",
							$time, want.val, found_value);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				answer_q.push_back(map_apply(opcode, key, value));
			pending = answer_q.size();
		end
	end

endmodule

>>> sim/tb_linear_probe_hash_map.sv
// Testbench top for the hash map: drives request beats and response stalls, gives the verdict.
`timescale 1ns / 100ps
module tb_linear_probe_hash_map;
	import lphm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 410;
	localparam int TAIL_CYCLES    = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         opcode = OP_INSERT;
	logic signed [31:0] key = '0;
	logic signed [31:0] value = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] found_value;

	int                 fail_count;
	int                 pending;
	int                 req_idle_pct = 0;
	int                 rsp_stall_pct = 0;
	bit                 hold_arm = 1'b0;
	bit                 hold_done = 1'b0;
	int                 idle_cycles = 0;
	logic signed [31:0] key_pool [$];

	always #5 clk = ~clk;

	linear_probe_hash_map u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found_value (found_value)
	);

	map_response_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found_value (found_value),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	task automatic send_beat(input logic [1:0] op, input logic signed [31:0] k,
			input logic signed [31:0] v);
		@(negedge clk);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		opcode = op;
		key = k;
		value = v;
		do begin
			@(posedge clk);
		end while (req_stall);
	endtask

	initial begin : rsp_side
		forever begin
			@(negedge clk);
			if (hold_arm && !hold_done) begin
				hold_done = 1'b1;
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_stall = ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : req_side
		int                 r;
		int                 ph;
		logic [1:0]         op;
		logic signed [31:0] k;
		logic signed [31:0] v;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_beat(OP_LOOKUP, 32'sh0000_0000, 32'sh0000_0000);
		send_beat(OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
		send_beat(OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
		send_beat(OP_INSERT, 32'sh0000_0000, 32'sh0000_0000);
		send_beat(OP_INSERT, 32'shffff_ffff, 32'shffff_ffff);
		send_beat(OP_INSERT, 32'sh8000_0000, 32'sh0000_0005);
		send_beat(OP_UPSERT, 32'sh7fff_ffff, 32'sh0000_0001);
		send_beat(OP_UPSERT, 32'sh1234_5678, 32'shdead_beef);
		send_beat(OP_UPSERT, 32'sh1234_5678, 32'sh0000_0000);
		send_beat(OP_LOOKUP, 32'sh8000_0000, 32'shffff_ffff);
		send_beat(OP_LOOKUP, 32'shffff_ffff, 32'sh0000_0000);
		send_beat(OP_LOOKUP, 32'sh0000_0000, 32'sh1234_5678);
		send_beat(OP_LOOKUP, 32'sh0000_0001, 32'sh0000_0000);
		send_beat(OP_SPARE,  32'sh7fff_ffff, 32'sh0000_0000);
		send_beat(OP_SPARE,  32'sh5555_5555, 32'shffff_ffff);
		send_beat(OP_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555);
		send_beat(OP_UPSERT, 32'sh5555_5555, 32'shaaaa_aaaa);
		send_beat(OP_LOOKUP, 32'sh5555_5555, 32'sh0000_0000);
		key_pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
			32'sh1234_5678, 32'shaaaa_aaaa, 32'sh5555_5555};

		for (ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			req_valid = 1'b0;
			wait (pending == 0);
			case (ph)
				0: begin
					req_idle_pct = 0;
					rsp_stall_pct = 0;
					hold_arm = 1'b1;
				end
				1: begin
					req_idle_pct = 63;
					rsp_stall_pct = 0;
				end
				2: begin
					req_idle_pct = 0;
					rsp_stall_pct = 63;
				end
				default: begin
					req_idle_pct = 35;
					rsp_stall_pct = 35;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 38)
					op = OP_INSERT;
				else if (r < 76)
					op = OP_UPSERT;
				else if (r < 94)
					op = OP_LOOKUP;
				else
					op = OP_SPARE;
				r = $urandom_range(99);
				if (r < 45) begin
					k = key_pool[$urandom_range(key_pool.size() - 1)];
				end else begin
					if (r < 48)
						k = ($urandom_range(1) != 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
					else
						k = $urandom;
					key_pool.push_back(k);
				end
				r = $urandom_range(99);
				if (r < 3)
					v = ($urandom_range(1) != 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
				else
					v = $urandom;
				send_beat(op, k, v);
			end
		end

		@(negedge clk);
		req_valid = 1'b0;
		wait (pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
